>>> sv/pcxd_pkg.sv
// Shared types and constants for the PCX 8bpp run-length decoder.
// No dependencies.
package pcxd_pkg;

  localparam int PixW = 8;
  localparam int CntW = 6;
  localparam int WordW = 2 * PixW;
  localparam logic [1:0] COUNT_MARK = 2'b11;

  typedef struct packed {
    logic [PixW-1:0] val;
    logic [CntW-1:0] count;
  } cmd_t;

endpackage

>>> sv/pcxd_front.sv
// Front end: takes coded bytes, tracks armed runs, emits pixel commands.
// Depends on pcxd_pkg.
module pcxd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         data_byte,
  output logic               push,
  output pcxd_pkg::cmd_t     cmd
);
  import pcxd_pkg::*;

  logic            run_pending;
  logic [CntW-1:0] run_length;
  logic            take;
  logic            is_count;

  assign take     = in_valid && !in_stall;
  assign is_count = (data_byte[7:6] == COUNT_MARK);

  always_comb begin
    cmd.val   = data_byte;
    cmd.count = run_pending ? run_length : CntW'(1);
    push      = take && (run_pending ? (run_length != '0) : !is_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_pending <= 1'b0;
      run_length  <= '0;
    end else if (take) begin
      if (run_pending) begin
        run_pending <= 1'b0;
        run_length  <= '0;
      end else if (is_count) begin
        run_pending <= 1'b1;
        run_length  <= data_byte[CntW-1:0];
      end
    end
  end

endmodule

>>> sv/pcxd_fifo.sv
// Two-entry command queue between front and back end.
// Depends on pcxd_pkg.
module pcxd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pcxd_pkg::cmd_t wr_cmd,
  input  logic           pop,
  output logic           q_valid,
  output logic           full,
  output pcxd_pkg::cmd_t rd_cmd
);
  import pcxd_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_valid = (count != 2'd0);
  assign full    = (count == 2'd2);
  assign rd_cmd  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> sv/pcxd_back.sv
// Back end: expands pixel commands into packed 16-bit words, one per cycle
// if unstalled, keeping an odd pixel across commands. Depends on pcxd_pkg.
module pcxd_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  pcxd_pkg::cmd_t            q_cmd,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [pcxd_pkg::WordW-1:0] pixel_pair,
  output logic                      last_of_item
);
  import pcxd_pkg::*;

  logic [PixW-1:0] val;
  logic [CntW-1:0] rem;
  logic [PixW-1:0] held_pixel;
  logic            held_valid;
  logic            can_step;
  logic            word_fire;
  logic            word_last;
  logic [WordW-1:0] word;

  assign can_step = !out_valid || !out_stall;
  assign pop      = (rem == '0) && q_valid;

  always_comb begin
    word_fire = 1'b0;
    word_last = 1'b0;
    word      = {val, val};
    if (rem != '0 && can_step) begin
      if (held_valid) begin
        word_fire = 1'b1;
        word      = {val, held_pixel};
        word_last = (rem <= CntW'(2));
      end else if (rem >= CntW'(2)) begin
        word_fire = 1'b1;
        word_last = (rem <= CntW'(3));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem        <= '0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        rem <= q_cmd.count;
      end else if (rem != '0 && can_step) begin
        if (held_valid) begin
          rem        <= rem - CntW'(1);
          held_valid <= 1'b0;
        end else if (rem >= CntW'(2)) begin
          rem <= rem - CntW'(2);
        end else begin
          rem        <= '0;
          held_valid <= 1'b1;
        end
      end
      if (word_fire)       out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) val <= q_cmd.val;
    if (rem == CntW'(1) && !held_valid && can_step) held_pixel <= val;
    if (word_fire) begin
      pixel_pair   <= word;
      last_of_item <= word_last;
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst) pop |-> rem == '0)
    else $error("command loaded while busy");
  a_more_after: assert property (@(posedge clk) disable iff (rst)
    (word_fire && !word_last) |=> rem != '0)
    else $error("non-final word with no work left");
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (word_fire && word_last) |=> rem < CntW'(2))
    else $error("final word left pairs unsent");
  a_held_step: assert property (@(posedge clk) disable iff (rst)
    (word_fire && held_valid) |=> !held_valid)
    else $error("held pixel not consumed");

endmodule

>>> sv/pcx_rle_decode_pack16.sv
// PCX 8bpp run-length decoder: each input item is one coded byte; output items are 16-bit
// pixel pairs (earlier pixel in bits 7:0) with last_of_item on the final word of a byte.
// In the back end a literal byte is loaded and then stepped once. A run command is
// loaded and then stepped once per output word, with one more step when it leaves
// an odd pixel to hold. An output stall holds the stepping of both. Count bytes and
// zero-length runs make no words. The front end absorbs bytes into a two-entry command
// queue, and input is stalled when the queue is full; throughput is set by the back end,
// which emits at most one word per cycle.
// Depends on pcxd_pkg, pcxd_front, pcxd_fifo, pcxd_back.
module pcx_rle_decode_pack16 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 data_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pcxd_pkg::WordW-1:0] pixel_pair,
  output logic                       last_of_item
);
  import pcxd_pkg::*;

  logic push;
  cmd_t wr_cmd;
  cmd_t rd_cmd;
  logic q_valid;
  logic full;
  logic pop;

  assign in_stall = full;

  pcxd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .push      (push),
    .cmd       (wr_cmd)
  );

  pcxd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_cmd  (wr_cmd),
    .pop     (pop),
    .q_valid (q_valid),
    .full    (full),
    .rd_cmd  (rd_cmd)
  );

  pcxd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (rd_cmd),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_pair   (pixel_pair),
    .last_of_item (last_of_item)
  );

endmodule

>>> dv/tb_pcx_rle_decode_pack16.sv
`timescale 1ns / 1ps
// Testbench for pcx_rle_decode_pack16: directed and random coded byte streams, with words
// checked against an in-bench run-length expander. Depends on pcxd_pkg and the decoder RTL.
module tb_pcx_rle_decode_pack16;
  import pcxd_pkg::*;

  typedef struct packed {
    logic [WordW-1:0] pair;
    logic             last;
  } word_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [PixW-1:0]  data_byte;
  logic             out_valid;
  logic             out_stall;
  logic [WordW-1:0] pixel_pair;
  logic             last_of_item;

  // expander state
  logic            run_armed;
  logic [CntW-1:0] run_len;
  logic [PixW-1:0] held_pix;
  logic            held_vld;

  word_t pending_words[$];
  int    mismatches;
  int    send_idle_pct;
  int    stall_pct;

  pcx_rle_decode_pack16 dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_pair   (pixel_pair),
    .last_of_item (last_of_item)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #5_000_000;
    $display("FAIL pcx_rle_decode_pack16");
    $finish;
  end

  function automatic void add_pixel(input logic [PixW-1:0] p);
    word_t w;
    if (held_vld) begin
      w.pair = {p, held_pix};
      w.last = 1'b0;
      pending_words.push_back(w);
      held_vld = 1'b0;
    end else begin
      held_pix = p;
      held_vld = 1'b1;
    end
  endfunction

  function automatic void expand_byte(input logic [PixW-1:0] b);
    int prior_size;
    int i;
    prior_size = pending_words.size();
    if (run_armed) begin
      for (i = 0; i < run_len; i++) add_pixel(b);
      run_armed = 1'b0;
      run_len = '0;
    end else if (b[PixW-1:PixW-2] == COUNT_MARK) begin
      run_armed = 1'b1;
      run_len = b[CntW-1:0];
    end else begin
      add_pixel(b);
    end
    if (pending_words.size() > prior_size)
      pending_words[pending_words.size()-1].last = 1'b1;
  endfunction

  task automatic report_bad(input string what, input logic [WordW-1:0] exp_pair,
                            input logic exp_last);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected pair %h last %b, got pair %h last %b", $realtime, what,
               exp_pair, exp_last, pixel_pair, last_of_item);
  endtask

  // accept side first so a same-edge word finds its expectation
  always @(posedge clk) begin
    word_t exp_w;
    if (rst) begin
      run_armed <= 1'b0;
      run_len   <= '0;
      held_pix  <= '0;
      held_vld  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expand_byte(data_byte);
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          report_bad("unexpected word", 'x, 1'bx);
        end else begin
          exp_w = pending_words.pop_front();
          if (pixel_pair !== exp_w.pair || last_of_item !== exp_w.last)
            report_bad("word mismatch", exp_w.pair, exp_w.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_byte(input logic [PixW-1:0] b);
    int gaps;
    gaps = 0;
    while ($urandom_range(99) < send_idle_pct) gaps++;
    if (gaps > 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic test_literals();
    send_byte(8'h00);
    send_byte(8'hBF);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h40);
    send_byte(8'h3F);
  endtask

  // odd pixel held across a count byte and into a run
  task automatic test_odd_carry();
    send_byte(8'h5A);
    send_byte(8'hC3);
    send_byte(8'h21);
    send_byte(8'h66);
    send_byte(8'h77);
  endtask

  task automatic test_zero_run();
    send_byte(8'hC0);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'hC0);
    send_byte(8'hC0);
    send_byte(8'h56);
  endtask

  task automatic test_count_as_value();
    send_byte(8'hC2);
    send_byte(8'hFF);
    send_byte(8'hC1);
    send_byte(8'hC0);
    send_byte(8'h01);
  endtask

  // longest run plus held pixel: 32 words from one byte
  task automatic test_long_run();
    send_byte(8'h99);
    send_byte(8'hFF);
    send_byte(8'hA5);
  endtask

  task automatic test_random(input int count, input int sidle, input int ridle);
    int sent;
    int pick;
    logic [CntW-1:0] len;
    send_idle_pct = sidle;
    stall_pct = ridle;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        if ($urandom_range(99) < 80) len = CntW'($urandom_range(0, 15));
        else len = CntW'($urandom_range(0, 63));
        send_byte({COUNT_MARK, len});
        send_byte(PixW'($urandom_range(0, 255)));
        sent += 2;
      end else if (pick < 85) begin
        send_byte(PixW'($urandom_range(0, 8'hBF)));
        sent++;
      end else begin
        send_byte(PixW'($urandom_range(0, 255)));
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    mismatches = 0;
    send_idle_pct = 17;
    stall_pct = 71;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    data_byte <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_literals();
    test_odd_carry();
    test_zero_run();
    test_count_as_value();
    test_long_run();
    drain();

    test_random(29, 17, 71);
    test_random(29, 71, 17);
    test_random(29, 0, 0);

    repeat (64) @(posedge clk);
    if (pending_words.size() != 0) begin
      mismatches++;
      $display("%0d expected words never arrived", pending_words.size());
    end
    if (mismatches == 0) begin
      $display("PASS pcx_rle_decode_pack16");
    end else begin
      $display("FAIL pcx_rle_decode_pack16");
    end
    $finish;
  end

endmodule

>>> pcx_rle_decode_pack16.f
sv/pcxd_pkg.sv
sv/pcxd_front.sv
sv/pcxd_fifo.sv
sv/pcxd_back.sv
sv/pcx_rle_decode_pack16.sv
dv/tb_pcx_rle_decode_pack16.sv
